// ===== rtl/fwt_pkg.sv =====
package fwt_pkg;

  localparam int unsigned POS_W   = 11;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned SUM_W   = 42;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned DELTA_W = VAL_W + 1;

  localparam int unsigned MAX_SIZE_DEF = 1024;

  localparam logic [CFG_W-1:0] ACTIVE_SIZE_RST = CFG_W'(1024);

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [SUM_W-1:0] range_sum;
    logic             error;
  } result_t;

endpackage

// ===== rtl/fwt_ram.sv =====
module fwt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fwt_ctrl.sv =====
module fwt_ctrl #(
  parameter int unsigned MAX_SIZE = fwt_pkg::MAX_SIZE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [fwt_pkg::CFG_W-1:0]   size_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_op_i,
  input  logic [fwt_pkg::POS_W-1:0]   in_pos_i,
  input  logic [fwt_pkg::POS_W-1:0]   in_upper_i,
  input  logic [fwt_pkg::VAL_W-1:0]   in_value_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output fwt_pkg::result_t            res_o
);
  import fwt_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SIZE);
  localparam int unsigned WW = ((AW > POS_W) ? AW : POS_W) + 2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_DELTA,
    ST_SET_WALK,
    ST_Q_WALK,
    ST_Q_OUT
  } state_e;

  state_e             state_q;
  logic [AW-1:0]      clr_q;
  logic [WW-1:0]      size_q;
  logic [WW-1:0]      x_q;
  logic [WW-1:0]      y_q;
  logic [AW-1:0]      wa_q;
  logic [VAL_W-1:0]   val_q;
  logic [DELTA_W-1:0] delta_q;
  logic [SUM_W-1:0]   acc_q;
  logic               rd_vld_q;
  logic               rd_sub_q;
  result_t            res_q;

  logic [WW-1:0]      size_d;
  logic [WW-1:0]      pos_w;
  logic [WW-1:0]      upper_w;
  logic               in_fire;
  logic               set_ok;
  logic               q_err;
  logic [WW-1:0]      x_m1;
  logic [WW-1:0]      y_m1;
  logic [WW-1:0]      x_low;
  logic               set_more;
  logic [WW-1:0]      q_idx_m1;
  logic [SUM_W-1:0]   acc_d;
  logic [DELTA_W-1:0] delta_d;

  logic               node_we;
  logic [AW-1:0]      node_waddr;
  logic [SUM_W-1:0]   node_wdata;
  logic               node_re;
  logic [AW-1:0]      node_raddr;
  logic [SUM_W-1:0]   node_rdata;
  logic               pt_we;
  logic [AW-1:0]      pt_addr;
  logic [VAL_W-1:0]   pt_wdata;
  logic               pt_re;
  logic [VAL_W-1:0]   pt_rdata;

  assign size_d  = (WW'(size_i) > WW'(MAX_SIZE)) ? WW'(MAX_SIZE) : WW'(size_i);
  assign pos_w   = WW'(in_pos_i);
  assign upper_w = WW'(in_upper_i);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign set_ok = (pos_w != '0) && (pos_w <= size_d);
  assign q_err  = (pos_w == '0) || (upper_w == '0) || (pos_w > size_d) ||
                  (upper_w > size_d) || (pos_w > upper_w);

  assign x_m1     = x_q - WW'(1);
  assign y_m1     = y_q - WW'(1);
  assign x_low    = x_q & (~x_q + WW'(1));
  assign set_more = (x_q <= size_q);
  assign q_idx_m1 = (x_q != '0) ? x_m1 : y_m1;

  assign delta_d = {val_q[VAL_W-1], val_q} - {pt_rdata[VAL_W-1], pt_rdata};

  always_comb begin
    acc_d = acc_q;
    if (rd_vld_q) begin
      acc_d = rd_sub_q ? (acc_q - node_rdata) : (acc_q + node_rdata);
    end
  end

  always_comb begin
    node_we    = 1'b0;
    node_waddr = wa_q;
    node_wdata = node_rdata + {{(SUM_W-DELTA_W){delta_q[DELTA_W-1]}}, delta_q};
    node_re    = 1'b0;
    node_raddr = x_m1[AW-1:0];
    pt_we      = 1'b0;
    pt_re      = 1'b0;
    pt_addr    = x_m1[AW-1:0];
    pt_wdata   = val_q;
    case (state_q)
      ST_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr_q;
        node_wdata = '0;
        pt_we      = 1'b1;
        pt_addr    = clr_q;
        pt_wdata   = '0;
      end
      ST_SET_RD: begin
        pt_re = 1'b1;
      end
      ST_SET_DELTA: begin
        pt_we   = 1'b1;
        node_re = 1'b1;
      end
      ST_SET_WALK: begin
        node_we = 1'b1;
        node_re = set_more;
      end
      ST_Q_WALK: begin
        node_re    = (x_q != '0) || (y_q != '0);
        node_raddr = q_idx_m1[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_sub_q <= 1'b0;
      size_q   <= '0;
      x_q      <= '0;
      y_q      <= '0;
      wa_q     <= '0;
      val_q    <= '0;
      delta_q  <= '0;
      acc_q    <= '0;
      res_q    <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MAX_SIZE - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            size_q   <= size_d;
            val_q    <= in_value_i;
            acc_q    <= '0;
            rd_vld_q <= 1'b0;
            if (in_op_i == OP_SET) begin
              x_q <= pos_w;
              if (set_ok) begin
                state_q <= ST_SET_RD;
              end
            end else if (q_err) begin
              res_q.range_sum <= '0;
              res_q.error     <= 1'b1;
              state_q         <= ST_Q_OUT;
            end else begin
              x_q     <= upper_w;
              y_q     <= pos_w - WW'(1);
              state_q <= ST_Q_WALK;
            end
          end
        end
        ST_SET_RD: begin
          state_q <= ST_SET_DELTA;
        end
        ST_SET_DELTA: begin
          delta_q <= delta_d;
          wa_q    <= x_m1[AW-1:0];
          x_q     <= x_q + x_low;
          state_q <= ST_SET_WALK;
        end
        ST_SET_WALK: begin
          if (set_more) begin
            wa_q <= x_m1[AW-1:0];
            x_q  <= x_q + x_low;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_Q_WALK: begin
          acc_q <= acc_d;
          if (x_q != '0) begin
            x_q      <= x_q & x_m1;
            rd_vld_q <= 1'b1;
            rd_sub_q <= 1'b0;
          end else if (y_q != '0) begin
            y_q      <= y_q & y_m1;
            rd_vld_q <= 1'b1;
            rd_sub_q <= 1'b1;
          end else begin
            rd_vld_q        <= 1'b0;
            res_q.range_sum <= acc_d;
            res_q.error     <= 1'b0;
            state_q         <= ST_Q_OUT;
          end
        end
        ST_Q_OUT: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = (state_q == ST_Q_OUT);
  assign res_o       = res_q;

  fwt_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_SIZE),
    .AW    (AW)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  fwt_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_SIZE),
    .AW    (AW)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_addr),
    .wdata_i (pt_wdata),
    .re_i    (pt_re),
    .raddr_i (pt_addr),
    .rdata_o (pt_rdata)
  );

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SET_WALK |-> WW'(wa_q) < size_q)
    else $error("node update beyond active size");

  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_we && node_re && state_q != ST_CLEAR |-> node_waddr != node_raddr)
    else $error("node read and write hit the same entry");

  a_error_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_q.error |-> res_q.range_sum == '0)
    else $error("error result carries a nonzero sum");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_q))
    else $error("pending result lost");

endmodule

// ===== rtl/fenwick_tree_point_set_range_sum_unit.sv =====
// channel   dir  signals                       contents (low bit first)
// s_axis    in   tvalid/tready/tdata/tuser     tdata: position, upper, value; tuser: operation
// m_axis    out  tvalid/tready/tdata/tuser     tdata: range_sum; tuser: error
// cfg       in   cfg_we_i/cfg_wdata_i          active_size
//
// set: read old value, form delta, then update up to log2 size + 1 nodes; an invalid set is ignored
// query: one node memory read per node of both prefix walks; rejected query: no walks
// one item in flight at a time; the node memory read port sets the pace of the walks
// after reset both memories are cleared one entry a cycle, all MAX_SIZE entries, tready low
// a finished query waits in the output register while the next transaction is taken
module fenwick_tree_point_set_range_sum_unit #(
  parameter int unsigned MAX_SIZE = fwt_pkg::MAX_SIZE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fwt_pkg::CFG_W-1:0]   cfg_wdata_i,  // active_size
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [55:0]                 s_axis_tdata, // position, upper, value
  input  logic                        s_axis_tuser, // operation
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [47:0]                 m_axis_tdata, // range_sum
  output logic                        m_axis_tuser  // error
);
  import fwt_pkg::*;

  logic [CFG_W-1:0] active_size_q;
  logic             out_valid_q;
  result_t          out_q;
  logic             res_valid;
  logic             res_ready;
  result_t          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_size_q <= ACTIVE_SIZE_RST;
    end else if (cfg_we_i) begin
      active_size_q <= cfg_wdata_i;
    end
  end

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      out_q       <= res;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  fwt_ctrl #(
    .MAX_SIZE (MAX_SIZE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_i      (active_size_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_pos_i    (s_axis_tdata[POS_W-1:0]),
    .in_upper_i  (s_axis_tdata[2*POS_W-1:POS_W]),
    .in_value_i  (s_axis_tdata[2*POS_W+VAL_W-1:2*POS_W]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(48-SUM_W){1'b0}}, out_q.range_sum};
  assign m_axis_tuser  = out_q.error;

endmodule
